FILE: rtl/core/efra_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and sequencer states for the earliest free room allocator
// no dependencies; imported by every module of the block

package efra_pkg;

  localparam int MAX_ROOMS = 16;
  localparam int TIME_BITS = 40;                      // at least 32, the request time width
  localparam int ROOM_W    = $clog2(MAX_ROOMS);
  localparam int CNT_W     = $clog2(MAX_ROOMS + 1);
  localparam int CFG_W     = 5;
  localparam int REQ_W     = 32;
  localparam int COUNT_W   = 32;

  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]     ROOMS_RESET = CFG_W'(MAX_ROOMS);

  localparam logic KIND_BOOK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_UPD
  } state_t;

  // outcome of a room scan
  typedef struct packed {
    logic                  found;
    logic [ROOM_W-1:0]     room;
    logic [TIME_BITS-1:0]  start;
  } scan_res_t;

  // write port of the room file
  typedef struct packed {
    logic                  en;
    logic [ROOM_W-1:0]     idx;
    logic [TIME_BITS-1:0]  busy;
    logic [COUNT_W-1:0]    count;
  } rf_wr_t;

endpackage

FILE: rtl/core/earliest_free_room_allocator.sv
`timescale 1ns / 1ps
// earliest free room allocator: booking requests in, room assignments out
// a booking word runs the room scan, then the finish and update stages; the update
// stage waits while the output register holds an untaken result; the scan visits the
// active rooms one per cycle via the shared compare unit; words are taken only while idle
// reset (rst, synchronous, active high): all rooms free, counts zero, most-booked room 0,
// rooms_in_use 16; no clearing pass, the block is ready in the cycle after reset

module earliest_free_room_allocator (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: rooms_in_use
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [efra_pkg::CFG_W-1:0]     cfg_data,
  // request words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [efra_pkg::REQ_W-1:0]     start_time,
  input  logic [efra_pkg::REQ_W-1:0]     end_time,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [efra_pkg::ROOM_W-1:0]    room,
  output logic [efra_pkg::TIME_BITS-1:0] actual_start,
  output logic [efra_pkg::TIME_BITS-1:0] actual_end,
  output logic                           delayed,
  output logic [efra_pkg::ROOM_W-1:0]    most_booked_room
);
  import efra_pkg::*;

  state_t state, state_next;

  // configuration
  logic [CFG_W-1:0]   rooms_in_use;
  logic [CNT_W-1:0]   n_active;
  logic [ROOM_W-1:0]  last_idx;

  // request and scan
  logic [TIME_BITS-1:0] req_start;
  logic [REQ_W-1:0]     req_len;
  logic [ROOM_W-1:0]    scan_idx;
  logic                 scan_last;
  scan_res_t            scan_res;

  // finish stage results
  logic [ROOM_W-1:0]    res_room;
  logic [TIME_BITS-1:0] res_start;
  logic [TIME_BITS-1:0] res_end;
  logic                 res_delayed;
  logic [COUNT_W-1:0]   res_count;
  logic [TIME_BITS:0]   end_sum;
  logic [TIME_BITS-1:0] end_sat;
  logic [COUNT_W-1:0]   count_rd;
  logic [COUNT_W-1:0]   count_inc;

  // most-booked tracking
  logic [ROOM_W-1:0]    best_room;
  logic [COUNT_W-1:0]   best_count;
  logic                 best_take;
  logic [ROOM_W-1:0]    best_room_next;

  // room file
  logic [TIME_BITS-1:0] busy_rd;
  rf_wr_t               rf_wr;

  // sequencer controls
  logic accept;
  logic clear_en;
  logic load_req;
  logic scan_step;
  logic fin_en;
  logic upd_en;
  logic out_free;

  // ---------------------------------------------------------------------------
  // configuration register, always writable, unchecked: the user must see it is written only while idle
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= ROOMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rooms_in_use <= cfg_data;
    end
  end

  // zero acts as one room, anything above the table size as the full table
  always_comb begin
    if (rooms_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (CNT_W'(rooms_in_use) > CNT_W'(MAX_ROOMS)) begin
      n_active = CNT_W'(MAX_ROOMS);
    end else begin
      n_active = CNT_W'(rooms_in_use);
    end
  end

  assign last_idx  = ROOM_W'(n_active - CNT_W'(1));
  assign scan_last = (scan_idx == last_idx);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && kind == KIND_BOOK) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    scan_step = 1'b0;
    fin_en    = 1'b0;
    upd_en    = 1'b0;
    case (state)
      S_IDLE:  in_ready  = 1'b1;
      S_SCAN:  scan_step = 1'b1;
      S_FIN:   fin_en    = 1'b1;
      S_UPD:   upd_en    = out_free;
      default: in_ready  = 1'b0;
    endcase
  end

  assign load_req = accept && (kind == KIND_BOOK);
  assign clear_en = accept && (kind == KIND_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // request capture: start widened to the time range, length clamped at zero
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_req) begin
      req_start <= TIME_BITS'(start_time);
      req_len   <= (end_time > start_time) ? (end_time - start_time) : '0;
    end
  end

  // scan index walks rooms 0 .. n-1, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (load_req) begin
      scan_idx <= '0;
    end else if (scan_step && !scan_last) begin
      scan_idx <= scan_idx + ROOM_W'(1);
    end
  end

  efra_room_file u_room_file (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear_en),
    .wr        (rf_wr),
    .busy_idx  (scan_idx),
    .busy_val  (busy_rd),
    .count_idx (scan_res.room),
    .count_val (count_rd)
  );

  efra_scan_unit u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (scan_step),
    .first     (scan_idx == '0),
    .idx       (scan_idx),
    .busy      (busy_rd),
    .req_start (req_start),
    .res       (scan_res)
  );

  // ---------------------------------------------------------------------------
  // finish stage: saturating end time and bumped booking count
  // ---------------------------------------------------------------------------
  assign end_sum   = {1'b0, scan_res.start} + (TIME_BITS + 1)'(req_len);
  assign end_sat   = (end_sum > {1'b0, TIME_MAX}) ? TIME_MAX : end_sum[TIME_BITS-1:0];
  assign count_inc = (count_rd == COUNT_MAX) ? count_rd : count_rd + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (fin_en) begin
      res_room    <= scan_res.room;
      res_start   <= scan_res.start;
      res_end     <= end_sat;
      res_delayed <= !scan_res.found;
      res_count   <= count_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // update stage: write the room back, track the most-booked room, load output
  // ---------------------------------------------------------------------------
  always_comb begin
    rf_wr.en    = upd_en;
    rf_wr.idx   = res_room;
    rf_wr.busy  = res_end;
    rf_wr.count = res_count;
  end

  assign best_take = (res_count > best_count) ||
                     ((res_count == best_count) && (res_room < best_room));
  assign best_room_next = best_take ? res_room : best_room;

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      best_room  <= '0;
      best_count <= '0;
    end else if (upd_en && best_take) begin
      best_room  <= res_room;
      best_count <= res_count;
    end
  end

  // output register parts the result side from the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      room             <= res_room;
      actual_start     <= res_start;
      actual_end       <= res_end;
      delayed          <= res_delayed;
      most_booked_room <= best_room_next;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_idx <= last_idx)
    else $error("scan index past last active room");

  a_book_starts_scan: assert property (@(posedge clk) disable iff (rst)
    load_req |=> state == S_SCAN && scan_idx == '0)
    else $error("booking word did not start a scan at room 0");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_UPD)
    else $error("result word raised outside the update step");

  a_room_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> scan_res.room <= last_idx)
    else $error("chosen room outside the active rooms");

  a_end_not_before_start: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> res_end >= res_start)
    else $error("booking ends before it starts");

endmodule

FILE: rtl/core/efra_room_file.sv
`timescale 1ns / 1ps
// per-room busy-until times and booking counts, one read port per array
// depends on efra_pkg

module efra_room_file (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  efra_pkg::rf_wr_t              wr,
  input  logic [efra_pkg::ROOM_W-1:0]   busy_idx,
  output logic [efra_pkg::TIME_BITS-1:0] busy_val,
  input  logic [efra_pkg::ROOM_W-1:0]   count_idx,
  output logic [efra_pkg::COUNT_W-1:0]  count_val
);
  import efra_pkg::*;

  logic [TIME_BITS-1:0] busy_until    [MAX_ROOMS];
  logic [COUNT_W-1:0]   booking_count [MAX_ROOMS];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_ROOMS; i++) begin
        busy_until[i]    <= '0;
        booking_count[i] <= '0;
      end
    end else if (wr.en) begin
      busy_until[wr.idx]    <= wr.busy;
      booking_count[wr.idx] <= wr.count;
    end
  end

  assign busy_val  = busy_until[busy_idx];
  assign count_val = booking_count[count_idx];

endmodule

FILE: rtl/core/efra_scan_unit.sv
`timescale 1ns / 1ps
// compare unit stepped over the rooms: first free room and earliest busy room
// depends on efra_pkg

module efra_scan_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           first,
  input  logic [efra_pkg::ROOM_W-1:0]    idx,
  input  logic [efra_pkg::TIME_BITS-1:0] busy,
  input  logic [efra_pkg::TIME_BITS-1:0] req_start,
  output efra_pkg::scan_res_t            res
);
  import efra_pkg::*;

  logic                 free_found;
  logic [ROOM_W-1:0]    free_idx;
  logic [TIME_BITS-1:0] min_val;
  logic [ROOM_W-1:0]    min_idx;
  logic                 hit;
  logic                 lower;

  assign hit   = (busy <= req_start);
  assign lower = (busy < min_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_found <= 1'b0;
    end else if (step) begin
      if (first) begin
        free_found <= hit;
      end else if (hit) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (first) begin
        free_idx <= idx;
        min_val  <= busy;
        min_idx  <= idx;
      end else begin
        if (!free_found && hit) begin
          free_idx <= idx;
        end
        // strict less keeps the lowest index on ties
        if (lower) begin
          min_val <= busy;
          min_idx <= idx;
        end
      end
    end
  end

  always_comb begin
    res.found = free_found;
    res.room  = free_found ? free_idx : min_idx;
    res.start = free_found ? req_start : min_val;
  end

endmodule

FILE: tb/sv/earliest_free_room_allocator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for earliest_free_room_allocator: directed and random bookings
// against a room-scan predictor; depends on efra_pkg and the block's rtl only

// one result word as the block reports it
typedef struct packed {
  logic [efra_pkg::ROOM_W-1:0]    room;
  logic [efra_pkg::TIME_BITS-1:0] start_at;
  logic [efra_pkg::TIME_BITS-1:0] end_at;
  logic                           late;
  logic [efra_pkg::ROOM_W-1:0]    top_room;
} booking_t;

// tracks rooms and counts, predicts each booking and checks the result words in order
class room_booking_scoreboard;
  logic [efra_pkg::TIME_BITS-1:0] free_at[efra_pkg::MAX_ROOMS];
  logic [efra_pkg::COUNT_W-1:0]   bookings[efra_pkg::MAX_ROOMS];
  logic [efra_pkg::ROOM_W-1:0]    top_room;
  logic [efra_pkg::COUNT_W-1:0]   top_count;
  logic [efra_pkg::CFG_W-1:0]     room_setting;
  booking_t                       expected_q[$];
  int mismatches;
  int booked;
  int clears;
  int checked;
  int late_seen;

  function new();
    wipe();
    room_setting = efra_pkg::ROOMS_RESET;
  endfunction

  function void wipe();
    foreach (free_at[i]) begin
      free_at[i]  = '0;
      bookings[i] = '0;
    end
    top_room  = '0;
    top_count = '0;
  endfunction

  function void set_rooms(logic [efra_pkg::CFG_W-1:0] v);
    room_setting = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // called for every accepted request word
  function void note_word(logic k, logic [efra_pkg::REQ_W-1:0] s, logic [efra_pkg::REQ_W-1:0] e);
    logic [efra_pkg::TIME_BITS-1:0] req_at, span, begin_at, finish_at;
    int n;
    int slot;
    bit hit;
    booking_t b;
    if (k == efra_pkg::KIND_CLEAR) begin
      wipe();
      clears++;
      return;
    end
    booked++;
    span   = (e > s) ? efra_pkg::TIME_BITS'(e - s) : '0;
    req_at = efra_pkg::TIME_BITS'(s);
    // out-of-range setting: zero acts as one, above the room file as all rooms
    n = (room_setting == 0) ? 1 :
        (room_setting > efra_pkg::MAX_ROOMS) ? efra_pkg::MAX_ROOMS : int'(room_setting);
    hit  = 1'b0;
    slot = 0;
    for (int i = 0; i < n; i++) begin
      if (!hit && free_at[i] <= req_at) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      begin_at = req_at;
    end else begin
      // no room free: earliest busy-until, lowest index on ties
      slot = 0;
      for (int i = 1; i < n; i++) begin
        if (free_at[i] < free_at[slot]) slot = i;
      end
      begin_at = free_at[slot];
    end
    finish_at = (span > efra_pkg::TIME_MAX - begin_at) ? efra_pkg::TIME_MAX : begin_at + span;
    free_at[slot] = finish_at;
    if (bookings[slot] != efra_pkg::COUNT_MAX) bookings[slot]++;
    if (bookings[slot] > top_count || (bookings[slot] == top_count && slot < top_room)) begin
      top_count = bookings[slot];
      top_room  = efra_pkg::ROOM_W'(slot);
    end
    b.room     = efra_pkg::ROOM_W'(slot);
    b.start_at = begin_at;
    b.end_at   = finish_at;
    b.late     = !hit;
    b.top_room = top_room;
    expected_q.push_back(b);
  endfunction

  function void check_result(booking_t got);
    booking_t want;
    checked++;
    if (got.late) late_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result word with no booking pending: room %0d start %0d end %0d",
                 $time, got.room, got.start_at, got.end_at);
      return;
    end
    want = expected_q.pop_front();
    if (got.room != want.room || got.start_at != want.start_at || got.end_at != want.end_at ||
        got.late != want.late || got.top_room != want.top_room) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch, expected room %0d start %0d end %0d delayed %0b top %0d",
                 $time, want.room, want.start_at, want.end_at, want.late, want.top_room);
        $display("%0t:           actual   room %0d start %0d end %0d delayed %0b top %0d",
                 $time, got.room, got.start_at, got.end_at, got.late, got.top_room);
      end
    end
  endfunction
endclass

module earliest_free_room_allocator_tb;
  import efra_pkg::*;

  // settle wait: enough for a booking that scans every room, with margin for the other states
  localparam int SETTLE_CYCLES = MAX_ROOMS + 8;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 kind;
  logic [REQ_W-1:0]     start_time;
  logic [REQ_W-1:0]     end_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [ROOM_W-1:0]    room;
  logic [TIME_BITS-1:0] actual_start;
  logic [TIME_BITS-1:0] actual_end;
  logic                 delayed;
  logic [ROOM_W-1:0]    most_booked_room;

  room_booking_scoreboard sb = new();

  // steady turns off idling on both sides; hold_pending asks the receiver for a long stall
  bit steady;
  bit hold_pending;
  int hold_left;
  int cfg_writes;

  earliest_free_room_allocator u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .start_time       (start_time),
    .end_time         (end_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .room             (room),
    .actual_start     (actual_start),
    .actual_end       (actual_end),
    .delayed          (delayed),
    .most_booked_room (most_booked_room)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #(5_000_000);
    $display("earliest_free_room_allocator verification failed");
    $finish;
  end

  // receiver: random stalls, a no-stall stretch, and one long hold counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_left    = 400;
        hold_pending = 1'b0;
      end
      if (rst) begin
        out_ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= 30);
      end
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({room, actual_start, actual_end, delayed, most_booked_room});
    end
  end

  // offer one request word, idling at random first; returns right after the accepting edge
  task automatic send_word(input logic k, input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = k;
    start_time = s;
    end_time   = e;
    do @(posedge clk); while (!in_ready);
    sb.note_word(k, s, e);
  endtask

  // stop offering, wait for every pending result, then let a trailing clear settle
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rooms(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_rooms(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] settings[6];
    logic [REQ_W-1:0] cur;
    logic [REQ_W-1:0] span;
    logic [REQ_W:0]   fin;
    int unsigned      step;
    int unsigned      gap_max;
    int unsigned      len_max;
    int               roll;
    int               fails;

    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = KIND_BOOK;
    start_time = '0;
    end_time   = '0;
    steady     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: all sixteen rooms after reset
    send_word(KIND_BOOK, 32'd0, 32'd10);
    send_word(KIND_BOOK, 32'd0, 32'd5);
    send_word(KIND_BOOK, 32'd10, 32'd20);             // room free exactly at its busy-until
    send_word(KIND_BOOK, 32'd10, 32'd10);             // zero length
    send_word(KIND_BOOK, 32'd12, 32'd3);              // end before start
    send_word(KIND_CLEAR, 32'hDEAD_BEEF, 32'h1234_5678); // clear ignores its times
    send_word(KIND_BOOK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_BOOK, 32'd0, 32'hFFFF_FFFF);       // longest request, out of order
    send_word(KIND_BOOK, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    drain_results();

    // two rooms: delays and ties on the earliest busy-until
    write_rooms(CFG_W'(2));
    send_word(KIND_CLEAR, 32'd0, 32'd0);
    send_word(KIND_BOOK, 32'd100, 32'd200);
    send_word(KIND_BOOK, 32'd100, 32'd150);
    send_word(KIND_BOOK, 32'd100, 32'd300);
    send_word(KIND_BOOK, 32'd100, 32'd110);
    send_word(KIND_CLEAR, 32'd0, 32'd0);
    send_word(KIND_BOOK, 32'd0, 32'd50);
    send_word(KIND_BOOK, 32'd0, 32'd50);
    send_word(KIND_BOOK, 32'd0, 32'd20);              // tie, lowest room wins
    drain_results();

    // zero acts as one room, 31 as all rooms; most-booked kept across the change
    write_rooms(CFG_W'(0));
    send_word(KIND_BOOK, 32'd0, 32'd7);
    send_word(KIND_BOOK, 32'd0, 32'd7);
    drain_results();
    write_rooms(CFG_W'(31));
    send_word(KIND_BOOK, 32'd60, 32'd61);
    send_word(KIND_BOOK, 32'd60, 32'd90);
    drain_results();

    // random phases, each under its own room setting
    settings = '{CFG_W'(1), CFG_W'(16), CFG_W'(0), CFG_W'(31),
                 CFG_W'($urandom_range(15, 2)), CFG_W'($urandom_range(31))};
    for (int p = 0; p < 6; p++) begin
      write_rooms(settings[p]);
      if (p != 1) send_word(KIND_CLEAR, $urandom, $urandom);
      cur = (p % 2 == 1) ? $urandom : $urandom_range(1000);
      case ($urandom_range(2))
        0: gap_max = 2;
        1: gap_max = 20;
        default: gap_max = 1000;
      endcase
      case ($urandom_range(2))
        0: len_max = 10;
        1: len_max = 100;
        default: len_max = 5000;
      endcase
      steady = (p == 3);
      // long receiver hold while requests keep coming, so the block backs up
      if (p == 2) hold_pending = 1'b1;
      for (int i = 0; i < 100; i++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_word(KIND_CLEAR, $urandom, $urandom);
          cur = $urandom_range(1000);
        end else if (roll < 14) begin
          // noise: arbitrary times, any order
          send_word(KIND_BOOK, $urandom, $urandom);
        end else begin
          step = $urandom_range(gap_max);
          cur  = (cur > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : cur + step;
          roll = $urandom_range(99);
          if (roll < 5) span = '0;
          else if (roll < 8) span = $urandom;
          else span = $urandom_range(len_max, 1);
          fin = {1'b0, cur} + span;
          send_word(KIND_BOOK, cur, fin[REQ_W] ? '1 : fin[REQ_W-1:0]);
        end
      end
      drain_results();
      steady = 1'b0;
    end

    // one room and near-maximal lengths chain the busy-until into saturation
    write_rooms(CFG_W'(1));
    send_word(KIND_CLEAR, 32'd0, 32'd0);
    for (int i = 0; i < 300; i++) begin
      send_word(KIND_BOOK, REQ_W'(i), $urandom_range(32'hFFFF_FFFF, 32'hF000_0000));
    end
    drain_results();

    $display("covered %0d bookings (%0d delayed) and %0d clears over %0d room settings",
             sb.booked, sb.late_seen, sb.clears, cfg_writes);
    $display("%0d result words checked, %0d mismatches", sb.checked, sb.mismatches);
    fails = sb.mismatches + sb.pending();
    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    if (fails == 0) begin
      $display("earliest_free_room_allocator verification clean");
    end else begin
      $display("earliest_free_room_allocator verification failed");
    end
    $finish;
  end

endmodule

FILE: earliest_free_room_allocator.f
rtl/core/efra_pkg.sv
rtl/core/efra_room_file.sv
rtl/core/efra_scan_unit.sv
rtl/core/earliest_free_room_allocator.sv
tb/sv/earliest_free_room_allocator_tb.sv
